FILE: hw/rtl/slrg_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the shuffled Lehmer random generator.
package slrg_pkg;

	// Minimal standard multiplier and modulus 2^31-1
	localparam logic [14:0] LEH_MUL = 15'd16807;
	localparam logic [30:0] LEH_MOD = 31'h7FFF_FFFF;

	// Largest Q0.24 fraction handed out, just under one
	localparam logic [23:0] FRAC_MAX = 24'd16777213;

	// Fixed-point shift of the reciprocal used for the slot quotient
	localparam int RECIP_SH = 40;

	// Input word
	typedef struct packed {
		logic              load_seed;
		logic signed [31:0] seed;
	} item_t;

	// Output word
	typedef struct packed {
		logic [30:0] deviate;
		logic [23:0] fraction;
		logic [30:0] next_state;
	} result_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;     // capture an accepted input word
		logic mul;      // register the Lehmer and slot products
		logic red_init; // reduce one table-fill step
		logic red_draw; // reduce the draw step, form the slot estimate
		logic slot_rd;  // correct the slot and read the table
		logic finish;   // swap the table entry and load the output
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic need_init; // accepted word must refill the table
		logic last_step; // table fill is on its final step
	} status_t;

endpackage

FILE: hw/rtl/slrg_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module slrg_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port: hold the data until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/slrg_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the shuffled Lehmer random generator.
module slrg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	output logic              result_valid,
	input  logic              result_ready,
	input  slrg_pkg::status_t status,
	output slrg_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_IMUL,
		ST_IRED,
		ST_DMUL,
		ST_DRED,
		ST_DSLOT,
		ST_DOUT
	} state_t;

	state_t state_q;
	logic   result_valid_q;

	// Decode commands from the current state
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = item_valid;
			end
			ST_IMUL, ST_DMUL: begin
				cmd.mul = 1'b1;
			end
			ST_IRED: begin
				cmd.red_init = 1'b1;
			end
			ST_DRED: begin
				cmd.red_draw = 1'b1;
			end
			ST_DSLOT: begin
				cmd.slot_rd = 1'b1;
			end
			ST_DOUT: begin
				cmd.finish = !result_valid_q || result_ready;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// Advance the sequence and track the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			// Raise the output flag on a finished draw, drop it once the word is taken
			if (cmd.finish) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						state_q <= status.need_init ? ST_IMUL : ST_DMUL;
					end
				end
				ST_IMUL: begin
					state_q <= ST_IRED;
				end
				ST_IRED: begin
					state_q <= status.last_step ? ST_DMUL : ST_IMUL;
				end
				ST_DMUL: begin
					state_q <= ST_DRED;
				end
				ST_DRED: begin
					state_q <= ST_DSLOT;
				end
				ST_DSLOT: begin
					state_q <= ST_DOUT;
				end
				ST_DOUT: begin
					if (cmd.finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = result_valid_q;

endmodule

FILE: hw/rtl/slrg_dp.sv
`timescale 1ns / 1ps
// Datapath: Lehmer step unit, slot quotient, shuffle table and output register.
module slrg_dp #(
	parameter int TABLE_DEPTH  = 32,
	parameter int WARMUP_STEPS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  slrg_pkg::item_t   item,
	input  slrg_pkg::cmd_t    cmd,
	output slrg_pkg::status_t status,
	output slrg_pkg::result_t result
);

	localparam int SLOT_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W  = $clog2(TABLE_DEPTH + WARMUP_STEPS);
	localparam longint unsigned SLOT_DIV_L =
		64'd1 + 64'd2147483646 / 64'(TABLE_DEPTH);
	localparam longint unsigned RECIP_L = (64'd1 << slrg_pkg::RECIP_SH) / SLOT_DIV_L;
	localparam int RECIP_W = $clog2(RECIP_L + 64'd1);
	localparam int SPROD_W = 31 + RECIP_W;
	localparam int QD_W    = 31 + SLOT_W;
	localparam logic [30:0]        SLOT_DIV = 31'(SLOT_DIV_L);
	localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(RECIP_L);
	localparam logic [CNT_W-1:0]   CNT_LOAD = CNT_W'(TABLE_DEPTH + WARMUP_STEPS - 1);

	// Generator state and working value
	logic [30:0]        x_q;
	logic [30:0]        lstate_q;
	logic [30:0]        shout_q;
	logic [CNT_W-1:0]   cnt_q;

	// Product and quotient stages
	logic [45:0]        lprod_s1;
	logic [SPROD_W-1:0] sprod_s1;
	logic [SLOT_W-1:0]  qe_s2;
	logic [QD_W-1:0]    qd_s2;
	logic [SLOT_W-1:0]  slot_q;
	slrg_pkg::result_t  result_q;

	// Combinational helpers
	logic               seed_is_mod;
	logic               s_neg;
	logic               s_zero;
	logic [30:0]        s_pos;
	logic [32:0]        neg_w;
	logic [30:0]        init_x;
	logic [31:0]        lsum;
	logic [30:0]        lred;
	logic [SLOT_W-1:0]  qe_w;
	logic [QD_W-1:0]    rem_w;
	logic [SLOT_W:0]    slot_inc;
	logic [SLOT_W-1:0]  slot_w;
	logic               cnt_in_tbl;
	logic               ram_we;
	logic [SLOT_W-1:0]  ram_waddr;
	logic [30:0]        ram_wdata;
	logic [30:0]        ram_rdata;
	logic [23:0]        frac_w;

	// Pick the starting value: loaded seed or stored state
	always_comb begin
		seed_is_mod = (item.seed == $signed({1'b0, slrg_pkg::LEH_MOD}));
		neg_w       = 33'd0 - {item.seed[31], item.seed};
		if (item.load_seed) begin
			s_neg  = item.seed[31];
			s_zero = (item.seed == 32'sd0) || seed_is_mod;
			s_pos  = item.seed[30:0];
		end else begin
			s_neg  = 1'b0;
			s_zero = (lstate_q == 31'd0);
			s_pos  = lstate_q;
		end
		// Negated seed reduced mod 2^31-1 and raised to at least one
		if (s_neg && (neg_w[32:31] == 2'b00) && (neg_w[30:0] != slrg_pkg::LEH_MOD)) begin
			init_x = neg_w[30:0];
		end else begin
			init_x = 31'd1;
		end
	end

	assign status.need_init = s_neg || s_zero || (shout_q == 31'd0);
	assign status.last_step = (cnt_q == '0);

	// Reduce the product mod 2^31-1: fold the high part onto the low part
	assign lsum = 32'(lprod_s1[45:31]) + 32'(lprod_s1[30:0]);
	assign lred = (lsum >= {1'b0, slrg_pkg::LEH_MOD}) ?
		31'(lsum - {1'b0, slrg_pkg::LEH_MOD}) : lsum[30:0];

	// Slot quotient: reciprocal estimate, then one compare and correct
	assign qe_w  = sprod_s1[slrg_pkg::RECIP_SH +: SLOT_W];
	assign rem_w = QD_W'(shout_q) - qd_s2;

	always_comb begin
		if (rem_w >= QD_W'(SLOT_DIV)) begin
			slot_inc = {1'b0, qe_s2} + (SLOT_W+1)'(1);
		end else begin
			slot_inc = {1'b0, qe_s2};
		end
		if (slot_inc >= (SLOT_W+1)'(TABLE_DEPTH)) begin
			slot_w = SLOT_W'(TABLE_DEPTH - 1);
		end else begin
			slot_w = slot_inc[SLOT_W-1:0];
		end
	end

	// Table port: fill during initialisation, swap at the end of a draw
	assign cnt_in_tbl = ({1'b0, cnt_q} < (CNT_W+1)'(TABLE_DEPTH));
	assign ram_we     = (cmd.red_init && cnt_in_tbl) || cmd.finish;
	assign ram_waddr  = cmd.finish ? slot_q : cnt_q[SLOT_W-1:0];
	assign ram_wdata  = cmd.finish ? lstate_q : lred;

	slrg_ram #(
		.WIDTH(31),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.slot_rd),
		.raddr(slot_w),
		.rdata(ram_rdata)
	);

	// Q0.24 fraction: deviate >> 7, clamped just below one
	assign frac_w = (ram_rdata[30:7] > slrg_pkg::FRAC_MAX) ?
		slrg_pkg::FRAC_MAX : ram_rdata[30:7];

	// Generator state and shuffle output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lstate_q <= 31'd0;
			shout_q  <= 31'd0;
		end else begin
			if (cmd.red_init && status.last_step) begin
				shout_q <= lred;
			end else if (cmd.finish) begin
				shout_q <= ram_rdata;
			end
			if (cmd.red_draw) begin
				lstate_q <= lred;
			end
		end
	end

	// Working value, step counter, product stages and output word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q   <= status.need_init ? init_x : s_pos;
			cnt_q <= CNT_LOAD;
		end else if (cmd.red_init) begin
			x_q <= lred;
			if (!status.last_step) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
		if (cmd.mul) begin
			lprod_s1 <= 46'(x_q) * 46'(slrg_pkg::LEH_MUL);
			sprod_s1 <= SPROD_W'(shout_q) * SPROD_W'(RECIP);
		end
		if (cmd.red_draw) begin
			qe_s2 <= qe_w;
			qd_s2 <= QD_W'(qe_w) * QD_W'(SLOT_DIV);
		end
		if (cmd.slot_rd) begin
			slot_q <= slot_w;
		end
		if (cmd.finish) begin
			result_q.deviate    <= ram_rdata;
			result_q.fraction   <= frac_w;
			result_q.next_state <= lstate_q;
		end
	end

	assign result = result_q;

endmodule

FILE: hw/rtl/shuffled_lehmer_random_generator_top.sv
`timescale 1ns / 1ps
// Top level of the shuffled Lehmer random generator.
// Each accepted word optionally loads a seed and yields one shuffled minimal-standard deviate,
// its Q0.24 fraction and the new generator state. One word is worked on at a time: item_ready
// stays low from acceptance until the draw is finished, which runs through the single Lehmer
// step unit (a registered multiply, then a fold-and-subtract reduction), the two-stage slot
// quotient and the one read and one write port of the shuffle table. A word that forces
// initialisation (first word after reset, or a zero, negative or 2^31-1 seed) first runs
// WARMUP_STEPS Lehmer steps and then refills the table one entry per Lehmer step. A finished
// result waits in the output register while the next word is accepted; that next draw then
// stalls in its last cycle until the waiting result is taken.
module shuffled_lehmer_random_generator_top #(
	parameter int TABLE_DEPTH  = 32,
	parameter int WARMUP_STEPS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  slrg_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output slrg_pkg::result_t result
);

	slrg_pkg::cmd_t    cmd;
	slrg_pkg::status_t status;

	slrg_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.status      (status),
		.cmd         (cmd)
	);

	slrg_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.WARMUP_STEPS(WARMUP_STEPS)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.cmd   (cmd),
		.status(status),
		.result(result)
	);

	// One word in flight: acceptance closes the input side
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> !item_ready)
		else $error("input accepted while a word is in flight");

	// Delivered deviates and states are never zero
	a_nonzero_out: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((result.deviate != 31'd0) && (result.next_state != 31'd0)))
		else $error("zero deviate or state delivered");

	// Fraction never exceeds its clamp limit
	a_frac_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.fraction <= slrg_pkg::FRAC_MAX))
		else $error("fraction above clamp");

endmodule
